// ----- src/ctld_pkg.sv -----
// shared types and codes for the transfer log deframer
package ctld_pkg;

  // transaction codes of a logged block
  localparam logic [7:0] CODE_DATA_M2H = 8'h20;
  localparam logic [7:0] CODE_RSIZE_LO = 8'h22;
  localparam logic [7:0] CODE_RSIZE_HI = 8'h23;
  localparam logic [7:0] CODE_DATA_H2M = 8'h28;
  localparam logic [7:0] CODE_WSIZE_LO = 8'h2A;
  localparam logic [7:0] CODE_WSIZE_HI = 8'h2B;
  localparam logic [7:0] TS_TOP_MASK   = 8'hE0;

  // timestamp field width within the time counter
  localparam int TS_FIELD_BITS = 11;
  localparam int TIME_W        = 44;

  // direction codes held in state
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_M2H  = 2'd1;
  localparam logic [1:0] DIR_H2M  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_CUT   = 2'd2;

  // one logged block
  typedef struct packed {
    logic [7:0] transaction_code;
    logic [7:0] payload_byte;
  } item_t;

  // one result
  typedef struct packed {
    logic [1:0]        kind;
    logic              direction;
    logic [15:0]       length;
    logic [7:0]        data_byte;
    logic [TIME_W-1:0] time_us;
    logic              last;
  } result_t;

endpackage

// ----- src/ctld_core.sv -----
// deframer state and per-block decode between the input and result registers
module ctld_core (
  input  logic            clk,
  input  logic            rst_n,
  input  ctld_pkg::item_t item,
  input  logic            advance,
  output logic            res_valid,
  output ctld_pkg::result_t res
);
  import ctld_pkg::*;

  logic              in_data_phase_r, in_data_phase_nxt;
  logic [1:0]        dir_code_r, dir_code_nxt;
  logic [15:0]       declared_len_r, declared_len_nxt;
  logic [1:0]        size_halves_r, size_halves_nxt;
  logic [15:0]       bytes_done_r, bytes_done_nxt;
  logic [TIME_W-1:0] time_counter_r, time_counter_nxt;

  // decode one block against the current state
  always_comb begin
    logic [7:0]  b;
    logic [7:0]  c;
    logic        is_size;
    logic        is_ts;
    logic        cut;
    logic [7:0]  want;
    logic [1:0]  d;
    logic        high;
    logic [15:0] done_inc;
    logic [TS_FIELD_BITS-1:0] ts_val;
    logic [1:0]  ts_pos;

    b        = item.payload_byte;
    c        = item.transaction_code;
    is_size  = (c == CODE_RSIZE_LO) || (c == CODE_RSIZE_HI) ||
               (c == CODE_WSIZE_LO) || (c == CODE_WSIZE_HI);
    is_ts    = (c & TS_TOP_MASK) == 8'h00;
    cut      = 1'b0;
    want     = (dir_code_r == DIR_H2M) ? CODE_DATA_H2M : CODE_DATA_M2H;
    d        = ((c == CODE_WSIZE_LO) || (c == CODE_WSIZE_HI)) ? DIR_H2M : DIR_M2H;
    high     = (c == CODE_RSIZE_HI) || (c == CODE_WSIZE_HI);
    done_inc = bytes_done_r + 16'd1;
    ts_val   = {c[2:0], b};
    ts_pos   = c[4:3];

    in_data_phase_nxt = in_data_phase_r;
    dir_code_nxt      = dir_code_r;
    declared_len_nxt  = declared_len_r;
    size_halves_nxt   = size_halves_r;
    bytes_done_nxt    = bytes_done_r;
    time_counter_nxt  = time_counter_r;

    res_valid     = 1'b0;
    res.kind      = KIND_DATA;
    res.direction = (dir_code_r == DIR_H2M);
    res.length    = 16'd0;
    res.data_byte = 8'd0;
    res.time_us   = time_counter_r;
    res.last      = 1'b0;

    // data phase: pass matching bytes, cut short on a size block, timestamps
    if (in_data_phase_r) begin
      if (c == want) begin
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = b;
        if (done_inc == declared_len_r) begin
          res.last          = 1'b1;
          in_data_phase_nxt = 1'b0;
          dir_code_nxt      = DIR_NONE;
          declared_len_nxt  = 16'd0;
          size_halves_nxt   = 2'd0;
          bytes_done_nxt    = 16'd0;
        end else begin
          bytes_done_nxt = done_inc;
        end
      end else if (is_size) begin
        res_valid         = 1'b1;
        res.kind          = KIND_CUT;
        res.length        = bytes_done_r;
        res.last          = 1'b1;
        cut               = 1'b1;
        in_data_phase_nxt = 1'b0;
        dir_code_nxt      = DIR_NONE;
        declared_len_nxt  = 16'd0;
        size_halves_nxt   = 2'd0;
        bytes_done_nxt    = 16'd0;
      end else if (is_ts) begin
        case (ts_pos)
          2'd0:    time_counter_nxt[0*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
          2'd1:    time_counter_nxt[1*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
          2'd2:    time_counter_nxt[2*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
          default: time_counter_nxt[3*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
        endcase
      end
    end

    // search: collect size halves, restart on a direction change
    if (is_size && (!in_data_phase_r || cut)) begin
      if (dir_code_nxt != d) begin
        declared_len_nxt = 16'd0;
        size_halves_nxt  = 2'd0;
      end
      dir_code_nxt = d;
      if (high) begin
        declared_len_nxt = declared_len_nxt | {b, 8'h00};
        size_halves_nxt  = size_halves_nxt | 2'b10;
      end else begin
        declared_len_nxt = declared_len_nxt | {8'h00, b};
        size_halves_nxt  = size_halves_nxt | 2'b01;
      end
      if ((size_halves_nxt == 2'b11) && !cut) begin
        res_valid     = 1'b1;
        res.kind      = KIND_START;
        res.direction = (d == DIR_H2M);
        res.length    = declared_len_nxt;
        if (declared_len_nxt == 16'd0) begin
          res.last          = 1'b1;
          in_data_phase_nxt = 1'b0;
          dir_code_nxt      = DIR_NONE;
          size_halves_nxt   = 2'd0;
          bytes_done_nxt    = 16'd0;
        end else begin
          in_data_phase_nxt = 1'b1;
          bytes_done_nxt    = 16'd0;
          size_halves_nxt   = 2'd0;
        end
      end
    end else if (!in_data_phase_r && is_ts) begin
      case (ts_pos)
        2'd0:    time_counter_nxt[0*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
        2'd1:    time_counter_nxt[1*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
        2'd2:    time_counter_nxt[2*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
        default: time_counter_nxt[3*TS_FIELD_BITS +: TS_FIELD_BITS] = ts_val;
      endcase
    end
  end

  // state registers, updated when a block moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_data_phase_r <= 1'b0;
      dir_code_r      <= DIR_NONE;
      declared_len_r  <= 16'd0;
      size_halves_r   <= 2'd0;
      bytes_done_r    <= 16'd0;
      time_counter_r  <= '0;
    end else if (advance) begin
      in_data_phase_r <= in_data_phase_nxt;
      dir_code_r      <= dir_code_nxt;
      declared_len_r  <= declared_len_nxt;
      size_halves_r   <= size_halves_nxt;
      bytes_done_r    <= bytes_done_nxt;
      time_counter_r  <= time_counter_nxt;
    end
  end

  // both halves never stay pending
  a_halves_drained: assert property (@(posedge clk) disable iff (!rst_n)
    size_halves_r != 2'b11)
    else $error("size halves left complete");

  // data phase always has a direction and a nonzero length
  a_data_phase_ok: assert property (@(posedge clk) disable iff (!rst_n)
    in_data_phase_r |-> ((dir_code_r == DIR_M2H) || (dir_code_r == DIR_H2M)) &&
                        (declared_len_r != 16'd0))
    else $error("data phase without direction or length");

  // a packet-ending result returns to search
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res.last) |=> !in_data_phase_r)
    else $error("still in data phase after final result");

  // a cut-short result is always final
  a_cut_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind == KIND_CUT)) |-> res.last)
    else $error("cut-short result without last");

endmodule

// ----- src/ci_transfer_log_deframer_unit.sv -----
// top level of the transfer log deframer: input register, core, result register
//
// Usage:
//   in_*  carries one 16-bit logged block per transaction (payload byte and
//         transaction code). out_* carries packet-start, data-byte and
//         cut-short results with the current microsecond time counter.
//   A block accepted into the input register is decoded from it there, and
//   its result is loaded into the result register when the block advances,
//   which raises out_tvalid; blocks that make no result just update state.
//   Throughput: one block per cycle unless a waiting result is held by a low
//   out_tready. The only loop is the state update in the core, so blocks
//   stream back to back.
//   Reset (rst_n low, synchronous) clears the search state, the time counter
//   and both registers; no result is pending afterwards.
//   When the receiver holds out_tready low with a result waiting, the block
//   in the input register waits and in_tready drops once that register is
//   full; a block may still be taken into an empty input register.
module ci_transfer_log_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // payload_byte [7:0], transaction_code [15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // length [15:0], data_byte [23:16], time_us [67:24], zero pad
  output logic [2:0]  out_tuser,  // kind [1:0], direction [2]
  output logic        out_tlast
);
  import ctld_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  logic    slot_free;
  logic    advance;
  logic    res_valid;
  result_t res;

  // handshake control
  assign slot_free     = !out_valid_r || out_tready;
  assign advance       = in_valid_r && slot_free;
  assign in_tready     = !in_valid_r || advance;
  assign out_valid_nxt = slot_free ? (advance && res_valid) : 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_t'(in_tdata);
    end
  end

  ctld_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_r),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.time_us, out_r.data_byte, out_r.length};
  assign out_tuser  = {out_r.direction, out_r.kind};
  assign out_tlast  = out_r.last;

endmodule

// ----- verif/ci_transfer_log_deframer_unit_tb.sv -----
// testbench for the transfer log deframer: directed and random logged blocks checked against a packet tracker
module ci_transfer_log_deframer_unit_tb;
  import ctld_pkg::*;

  localparam int BLOCK_TARGET = 1925;
  localparam int CYCLE_LIMIT  = 800000;

  // follows the log framing and holds the results it predicts
  class packet_tracker;
    bit                passing;
    logic [1:0]        dir;
    logic [15:0]       len_decl;
    logic [1:0]        halves;
    logic [15:0]       delivered;
    logic [TIME_W-1:0] usec;
    result_t           expected_results[$];
    int                errors;

    function new();
      restart_search();
      usec = '0;
      errors = 0;
    endfunction

    function void restart_search();
      passing = 1'b0;
      dir = DIR_NONE;
      len_decl = '0;
      halves = '0;
      delivered = '0;
    endfunction

    // a timestamp block overwrites one 11-bit slice of the counter
    function void set_time_field(logic [7:0] b, logic [7:0] c);
      logic [10:0] val;
      int shift;
      val = {c[2:0], b};
      shift = TS_FIELD_BITS * int'(c[4:3]);
      for (int i = 0; i < TS_FIELD_BITS; i++) usec[shift + i] = val[i];
    endfunction

    function void push(logic [1:0] kind, logic [15:0] n, logic [7:0] dbyte, logic last);
      result_t r;
      r.kind = kind;
      r.direction = (dir == DIR_H2M);
      r.length = n;
      r.data_byte = dbyte;
      r.time_us = usec;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    // one accepted block
    function void take_block(logic [7:0] b, logic [7:0] c);
      logic       is_size, is_ts, hi_half, cut;
      logic [1:0] d;
      logic [7:0] want;
      is_size = (c == CODE_RSIZE_LO) || (c == CODE_RSIZE_HI) ||
                (c == CODE_WSIZE_LO) || (c == CODE_WSIZE_HI);
      is_ts = (c & TS_TOP_MASK) == 8'h00;
      cut = 1'b0;
      if (passing) begin
        want = (dir == DIR_H2M) ? CODE_DATA_H2M : CODE_DATA_M2H;
        if (c == want) begin
          delivered = delivered + 16'd1;
          if (delivered == len_decl) begin
            push(KIND_DATA, 16'd0, b, 1'b1);
            restart_search();
          end else begin
            push(KIND_DATA, 16'd0, b, 1'b0);
          end
          return;
        end
        if (is_ts) begin
          set_time_field(b, c);
          return;
        end
        if (!is_size) return;
        // size block inside a packet: cut it short, then search with this block
        push(KIND_CUT, delivered, 8'd0, 1'b1);
        restart_search();
        cut = 1'b1;
      end
      if (is_size) begin
        d = ((c == CODE_WSIZE_LO) || (c == CODE_WSIZE_HI)) ? DIR_H2M : DIR_M2H;
        hi_half = (c == CODE_RSIZE_HI) || (c == CODE_WSIZE_HI);
        if (dir != d) begin
          len_decl = '0;
          halves = '0;
        end
        dir = d;
        if (hi_half) begin
          len_decl[15:8] = len_decl[15:8] | b;
          halves[1] = 1'b1;
        end else begin
          len_decl[7:0] = len_decl[7:0] | b;
          halves[0] = 1'b1;
        end
        if (halves == 2'b11 && !cut) begin
          if (len_decl == 16'd0) begin
            push(KIND_START, 16'd0, 8'd0, 1'b1);
            restart_search();
          end else begin
            push(KIND_START, len_decl, 8'd0, 1'b0);
            passing = 1'b1;
            delivered = '0;
            halves = '0;
          end
        end
      end else if (is_ts) begin
        set_time_field(b, c);
      end
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // one accepted result against the oldest prediction
    function void check_result(logic [71:0] tdata, logic [2:0] tuser, logic tlast);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with none pending: kind %0d length 0x%0h", tuser[1:0], tdata[15:0]);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", TIME_W'(want.kind), TIME_W'(tuser[1:0]));
      compare_field("direction", TIME_W'(want.direction), TIME_W'(tuser[2]));
      compare_field("length", TIME_W'(want.length), TIME_W'(tdata[15:0]));
      compare_field("data_byte", TIME_W'(want.data_byte), TIME_W'(tdata[23:16]));
      compare_field("time_us", want.time_us, tdata[67:24]);
      compare_field("pad", '0, TIME_W'(tdata[71:68]));
      compare_field("last", TIME_W'(want.last), TIME_W'(tlast));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  packet_tracker tracker = new();
  bit            no_idle = 1'b0;
  int            blocks_sent = 0;
  int            cycles = 0;

  ci_transfer_log_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // gap lengths: mostly short, a few long
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver back-pressure
  initial begin
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 99) < 12) begin
        out_tready = 1'b0;
        stall = pick_gap() - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.take_block(in_tdata[7:0], in_tdata[15:8]);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_block(input logic [7:0] b, input logic [7:0] c);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < 25) gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {c, b};
    do @(posedge clk); while (!in_tready);
    blocks_sent++;
  endtask

  // hold the sender until every predicted result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1)) send_block(8'($urandom), 8'($urandom_range(0, 255)));
    else send_block(8'($urandom), 8'($urandom_range(0, 31)));
  endtask

  // one size half, sometimes split over two blocks that are ORed together
  task automatic send_half(input logic [7:0] val, input logic [7:0] code);
    logic [7:0] mask;
    if ($urandom_range(0, 99) < 12) begin
      mask = 8'($urandom);
      send_block(val & mask, code);
      send_block(val & ~mask, code);
    end else begin
      send_block(val, code);
    end
  endtask

  // a size pair and data blocks of one direction, possibly cut short
  task automatic send_packet();
    int          r, stop_at;
    logic [15:0] n;
    bit          h2m;
    logic [7:0]  lo_code, hi_code, data_code, other_data;
    r = $urandom_range(0, 99);
    if (r < 5) n = 16'd0;
    else if (r < 85) n = 16'($urandom_range(1, 12));
    else if (r < 98) n = 16'($urandom);
    else n = 16'($urandom_range(200, 300));
    h2m = 1'($urandom_range(0, 1));
    lo_code = h2m ? CODE_WSIZE_LO : CODE_RSIZE_LO;
    hi_code = h2m ? CODE_WSIZE_HI : CODE_RSIZE_HI;
    data_code = h2m ? CODE_DATA_H2M : CODE_DATA_M2H;
    other_data = h2m ? CODE_DATA_M2H : CODE_DATA_H2M;
    stop_at = int'(n);
    if (n != 16'd0 && (n > 16'd300 || $urandom_range(0, 99) < 15))
      stop_at = $urandom_range(0, (n > 16'd12) ? 12 : int'(n) - 1);
    // stray half of the other direction, dropped when the direction changes
    if ($urandom_range(0, 99) < 5)
      send_block(8'($urandom), h2m ? CODE_RSIZE_LO : CODE_WSIZE_HI);
    if ($urandom_range(0, 1)) begin
      send_half(n[7:0], lo_code);
      send_half(n[15:8], hi_code);
    end else begin
      send_half(n[15:8], hi_code);
      send_half(n[7:0], lo_code);
    end
    for (int i = 0; i < stop_at; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_noise();
      else if (r < 9) send_block(8'($urandom), other_data);
      else if (r < 15) send_block(8'($urandom), 8'($urandom_range(0, 31)));
      send_block(8'($urandom), data_code);
    end
  endtask

  // directed blocks: payload byte, transaction code
  logic [7:0] directed_seq [25][2] = '{
    '{8'hFF, 8'h1F}, '{8'hFF, 8'h07}, '{8'h00, 8'h00}, '{8'h12, CODE_DATA_M2H},
    '{8'h77, 8'hFF}, '{8'h03, CODE_WSIZE_LO}, '{8'h00, CODE_WSIZE_HI},
    '{8'h00, CODE_DATA_H2M}, '{8'h5A, CODE_DATA_M2H}, '{8'hA5, 8'h18},
    '{8'hFF, CODE_DATA_H2M}, '{8'hAA, CODE_DATA_H2M}, '{8'h00, CODE_RSIZE_LO},
    '{8'h00, CODE_RSIZE_HI}, '{8'h05, CODE_WSIZE_LO}, '{8'h00, CODE_RSIZE_HI},
    '{8'h01, CODE_RSIZE_LO}, '{8'h02, CODE_RSIZE_LO}, '{8'hC3, CODE_DATA_M2H},
    '{8'h01, CODE_WSIZE_HI}, '{8'hFF, CODE_WSIZE_LO}, '{8'hFF, 8'hFF},
    '{8'hFF, CODE_RSIZE_HI}, '{8'hFF, CODE_RSIZE_LO}, '{8'h00, CODE_WSIZE_LO}
  };

  // main sequence
  initial begin
    bit paused;
    paused = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes, both directions, zero length, restarts, early cuts
    foreach (directed_seq[i]) send_block(directed_seq[i][0], directed_seq[i][1]);
    wait_drained();

    // random packets, some stretches without idling
    while (blocks_sent < BLOCK_TARGET) begin
      no_idle = ($urandom_range(0, 9) == 0);
      send_packet();
      if ($urandom_range(0, 99) < 4) send_noise();
      if (!paused && blocks_sent > BLOCK_TARGET / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ctld_pkg.sv
src/ctld_core.sv
src/ci_transfer_log_deframer_unit.sv
verif/ci_transfer_log_deframer_unit_tb.sv
